>>> hw/rtl/bsa_pkg.sv
// ============================================================================
// bsa_pkg
// Shared types and constants for the bitmap slot allocator.
// ============================================================================
package bsa_pkg;

   localparam int WORD_BITS     = 32;
   localparam int BIT_IDX_W     = 5;
   localparam int SLOT_W        = 11;
   localparam int STORE_WORDS   = 64;   // 11-bit slot index reaches 64 words
   localparam int NUM_WORDS_DEF = 64;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   // result of one read-modify-write of a bitmap word
   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [BIT_IDX_W-1:0] bit_sel;
      logic                 full;
   } upd_result_type;

endpackage

>>> hw/rtl/bsa_word_update.sv
// ============================================================================
// bsa_word_update
// Modifies one bitmap word: set lowest zero bit, or clear a given bit.
// ============================================================================
module bsa_word_update
   import bsa_pkg::*;
(
   input  logic                 op,
   input  logic [BIT_IDX_W-1:0] bit_idx,
   input  logic [WORD_BITS-1:0] word,
   output upd_result_type       result
);

   logic [BIT_IDX_W-1:0] low_zero;
   logic [BIT_IDX_W-1:0] sel;
   logic [WORD_BITS-1:0] onehot;
   logic [WORD_BITS-1:0] new_word;

   // lowest clear bit; priority from the top down so bit 0 wins
   always_comb begin
      low_zero = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            low_zero = BIT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      sel      = (op == OP_ALLOC) ? low_zero : bit_idx;
      onehot   = WORD_BITS'(1) << sel;
      new_word = (op == OP_ALLOC) ? (word | onehot) : (word & ~onehot);
      result.word    = new_word;
      result.bit_sel = sel;
      result.full    = &new_word;
   end

endmodule

>>> hw/rtl/bitmap_slot_allocator_unit.sv
// ============================================================================
// bitmap_slot_allocator_unit
// Occupancy bitmap allocator: allocate lowest free slot, release a slot.
// ============================================================================
// A request beat passes through ST_IDLE and ST_UPDATE: the bitmap lives in
// a synchronous RAM of 32-bit words, so the read is issued on accept and
// ST_UPDATE does modify and write-back; the next request follows write-back.
// A per-word full flag in flops picks the first non-full word at accept
// time, so allocation needs no scan of the RAM. A per-word valid bit makes
// a never-written word read as all free; there is no clearing pass after
// reset. The response sits in an output register, so a new request is
// accepted while an earlier response is still stalled. Allocate on a full
// bitmap returns slot 0 with status full; release of a slot beyond the
// words in use is ignored and answers slot 0, status ok.
// ============================================================================
module bitmap_slot_allocator_unit
   import bsa_pkg::*;
#(
   parameter int NUM_WORDS = NUM_WORDS_DEF
)(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [SLOT_W-1:0] req_slot_index,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SLOT_W-1:0] rsp_granted_slot,
   output logic              rsp_status
);

   // words actually present, capped by the slot index range
   localparam int WORDS = (NUM_WORDS > STORE_WORDS) ? STORE_WORDS : NUM_WORDS;
   localparam int WIDX  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WSEL_W = SLOT_W - BIT_IDX_W;

   // --- bitmap RAM ---
   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_en;
   logic [WIDX-1:0]      rd_addr;
   logic                 wr_en;

   // --- per-word flags ---
   logic [WORDS-1:0]     full_ff, full_in;
   logic [WORDS-1:0]     valid_ff, valid_in;

   // --- control and captured request ---
   state_type            state_ff, state_in;
   logic                 op_ff, op_in;
   logic [WIDX-1:0]      widx_ff, widx_in;
   logic [BIT_IDX_W-1:0] bidx_ff, bidx_in;
   logic                 skip_ff, skip_in;   // alloc failed or release out of range

   // --- response register ---
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]    granted_ff, granted_in;
   logic                 status_ff, status_in;

   // --- first non-full word ---
   logic                 free_found;
   logic [WIDX-1:0]      free_idx;
   logic [WSEL_W-1:0]    rel_word;
   logic                 rel_oob;
   logic                 go;
   logic [WORD_BITS-1:0] cur_word;
   upd_result_type       upd;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = WORDS - 1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            free_found = 1'b1;
            free_idx   = WIDX'(i);
         end
      end
   end

   assign rel_word = req_slot_index[SLOT_W-1:BIT_IDX_W];
   assign rel_oob  = {1'b0, rel_word} >= (WSEL_W + 1)'(WORDS);

   // never-written words read as all free
   assign cur_word = valid_ff[widx_ff] ? rd_data_ff : '0;

   bsa_word_update u_update (
      .op      (op_ff),
      .bit_idx (bidx_ff),
      .word    (cur_word),
      .result  (upd)
   );

   // RAM: registered read, one write port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[widx_ff] <= upd.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         full_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         full_ff      <= full_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      widx_ff    <= widx_in;
      bidx_ff    <= bidx_in;
      skip_ff    <= skip_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      widx_in      = widx_ff;
      bidx_in      = bidx_ff;
      skip_in      = skip_ff;
      full_in      = full_ff;
      valid_in     = valid_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      go           = !rsp_valid_ff || !rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            // stall is low here, so a valid beat is accepted
            req_stall = 1'b0;
            if (req_opcode == OP_ALLOC) begin
               rd_addr = free_idx;
            end else begin
               rd_addr = rel_word[WIDX-1:0];
            end
            if (req_valid) begin
               rd_en    = 1'b1;
               op_in    = req_opcode;
               widx_in  = rd_addr;
               bidx_in  = req_slot_index[BIT_IDX_W-1:0];
               skip_in  = (req_opcode == OP_ALLOC) ? !free_found : rel_oob;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (go) begin
               wr_en        = !skip_ff;
               rsp_valid_in = 1'b1;
               if (!skip_ff) begin
                  full_in[widx_ff]  = upd.full;
                  valid_in[widx_ff] = 1'b1;
               end
               if (op_ff == OP_ALLOC && !skip_ff) begin
                  granted_in = SLOT_W'({widx_ff, upd.bit_sel});
               end else begin
                  granted_in = '0;
               end
               status_in = (op_ff == OP_ALLOC && skip_ff) ? STATUS_FULL : STATUS_OK;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = granted_ff;
   assign rsp_status       = status_ff;

endmodule
